/* hw/rtl/cpt_pkg.sv */
package cpt_pkg;

  // coordinate and difference widths
  localparam int CW   = 32;
  localparam int DW   = CW + 1;
  // one dot-product term and the three-term sum
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  // half width used to split a dot product for the second products
  localparam int HL   = DOTW / 2;
  // products of two dot products and their differences
  localparam int VW   = 2 * DOTW + 1;
  // denominators and scalar multipliers
  localparam int ML   = 35;
  localparam int NML  = 4;
  localparam int DENW = ML * NML;
  // numerators, the doubled rounding numerator, divider remainder
  localparam int NUMW = DW + DENW + 3;
  localparam int NPW  = NUMW + 2;
  localparam int RW   = DENW + 2;
  // quotient bits; the quotient saturates at 2^(QW-1)
  localparam int QW   = 41;

  localparam logic [2:0] RG_A     = 3'd0;
  localparam logic [2:0] RG_B     = 3'd1;
  localparam logic [2:0] RG_AB    = 3'd2;
  localparam logic [2:0] RG_C     = 3'd3;
  localparam logic [2:0] RG_AC    = 3'd4;
  localparam logic [2:0] RG_BC    = 3'd5;
  localparam logic [2:0] RG_FACE  = 3'd6;
  localparam logic [2:0] RG_DEGEN = 3'd7;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [2:0][DW-1:0] ab;
    logic [2:0][DW-1:0] ac;
    logic [2:0][DW-1:0] bc;
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [2:0][CW-1:0] c;
  } geo_t;

  typedef struct packed {
    logic [2:0]         region;
    logic [2:0][CW-1:0] base;
    logic [2:0]         neg;
  } tag_t;

endpackage

/* hw/rtl/cpt_in_if.sv */
interface cpt_in_if;
  logic            valid;
  logic            ready;
  cpt_pkg::coord_t point_x;
  cpt_pkg::coord_t point_y;
  cpt_pkg::coord_t point_z;
  cpt_pkg::coord_t vert_a_x;
  cpt_pkg::coord_t vert_a_y;
  cpt_pkg::coord_t vert_a_z;
  cpt_pkg::coord_t vert_b_x;
  cpt_pkg::coord_t vert_b_y;
  cpt_pkg::coord_t vert_b_z;
  cpt_pkg::coord_t vert_c_x;
  cpt_pkg::coord_t vert_c_y;
  cpt_pkg::coord_t vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
    output vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
    input  vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

/* hw/rtl/cpt_out_if.sv */
interface cpt_out_if;
  logic            valid;
  logic            ready;
  cpt_pkg::coord_t near_x;
  cpt_pkg::coord_t near_y;
  cpt_pkg::coord_t near_z;
  logic [2:0]      region;

  modport source (output valid, near_x, near_y, near_z, region, input ready);
  modport sink (input valid, near_x, near_y, near_z, region, output ready);
endinterface

/* hw/rtl/cpt_div.sv */
// Pipelined restoring divider: one quotient bit per stage, with an
// up-front overflow check. Quotient saturates at 2^(QW-1).
module cpt_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cpt_pkg::NPW-1:0]   num,
  input  logic [cpt_pkg::RW-2:0]    den2,
  output logic [cpt_pkg::QW-1:0]    quo
);
  localparam int QW   = cpt_pkg::QW;
  localparam int NPW  = cpt_pkg::NPW;
  localparam int DEN2W = cpt_pkg::RW - 1;
  localparam int CMPW = DEN2W + QW + 1;
  localparam logic [QW-1:0] LIM = QW'(1) << (QW - 1);

  logic             sat [QW+1];
  logic [DEN2W-1:0] rem [QW+1];
  logic [DEN2W-1:0] dv  [QW+1];
  logic [QW-1:0]    lo  [QW+1];
  logic [QW-1:0]    q   [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= CMPW'(num) >= CMPW'({den2, {QW{1'b0}}});
      rem[0] <= DEN2W'(num[NPW-1:QW]);
      dv[0]  <= den2;
      lo[0]  <= num[QW-1:0];
      q[0]   <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DEN2W:0] t;
    logic [DEN2W:0] diff;
    logic           ge;

    always_comb begin
      t    = {rem[i], lo[i][QW-1]};
      diff = t - {1'b0, dv[i]};
      ge   = t >= {1'b0, dv[i]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat[i+1] <= sat[i];
        rem[i+1] <= ge ? diff[DEN2W-1:0] : t[DEN2W-1:0];
        dv[i+1]  <= dv[i];
        lo[i+1]  <= {lo[i][QW-2:0], 1'b0};
        q[i+1]   <= {q[i][QW-2:0], ge};
      end
    end
  end

  assign quo = (sat[QW] || q[QW] > LIM) ? LIM : q[QW];

endmodule

/* hw/rtl/closest_point_on_triangle_top.sv */
// Closest point on a triangle, by Voronoi region, signed Q16.16 in and out.
// Throughput: one beat per cycle while the skid buffer is empty; set by
// the 54-stage pipeline (12 stages of products and classification, then
// a 42-stage one-bit-per-stage divider). Reset (rst, synchronous, active
// high) clears all valid bits, including those of the output register and
// skid buffer; no state survives between items.
module closest_point_on_triangle_top (
  input logic       clk,
  input logic       rst,
  cpt_in_if.sink    req,
  cpt_out_if.source rsp
);
  localparam int CW   = cpt_pkg::CW;
  localparam int DW   = cpt_pkg::DW;
  localparam int PW   = cpt_pkg::PW;
  localparam int DOTW = cpt_pkg::DOTW;
  localparam int HL   = cpt_pkg::HL;
  localparam int VW   = cpt_pkg::VW;
  localparam int EW   = DOTW + 1;
  localparam int ML   = cpt_pkg::ML;
  localparam int MLX  = ML + 1;
  localparam int NML  = cpt_pkg::NML;
  localparam int DENW = cpt_pkg::DENW;
  localparam int PPW  = DW + MLX;
  localparam int NUMW = cpt_pkg::NUMW;
  localparam int NPW  = cpt_pkg::NPW;
  localparam int QW   = cpt_pkg::QW;
  localparam int TW   = QW + 2;
  localparam int NST  = 12 + QW + 1;
  // dot products d1..d6 sit at index 0..5; pairs feed vc, vb, va
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};
  localparam logic signed [TW-1:0] SMAX = TW'(32'sh7FFFFFFF);
  localparam logic signed [TW-1:0] SMIN = TW'(32'sh80000000);

  function automatic logic le0(input logic signed [DENW-1:0] x);
    return x[DENW-1] || (x == '0);
  endfunction

  // ---------------------------------------------------------------------
  // Flow control: every stage moves together unless the skid holds a beat.
  // ---------------------------------------------------------------------
  logic           en;
  logic [NST:1]   v;
  logic           ov;
  logic           sv;

  assign en        = !sv;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-1:1], req.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: edge vectors and point offsets
  // ---------------------------------------------------------------------
  cpt_pkg::coord_t in_p [3];
  cpt_pkg::coord_t in_a [3];
  cpt_pkg::coord_t in_b [3];
  cpt_pkg::coord_t in_c [3];

  assign in_p[0] = req.point_x;
  assign in_p[1] = req.point_y;
  assign in_p[2] = req.point_z;
  assign in_a[0] = req.vert_a_x;
  assign in_a[1] = req.vert_a_y;
  assign in_a[2] = req.vert_a_z;
  assign in_b[0] = req.vert_b_x;
  assign in_b[1] = req.vert_b_y;
  assign in_b[2] = req.vert_b_z;
  assign in_c[0] = req.vert_c_x;
  assign in_c[1] = req.vert_c_y;
  assign in_c[2] = req.vert_c_z;

  cpt_pkg::geo_t         g1, g2, g3, g4, g5, g6;
  logic signed [DW-1:0]  s1_ap [3];
  logic signed [DW-1:0]  s1_bp [3];
  logic signed [DW-1:0]  s1_cp [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g1.ab[k] <= DW'(in_b[k]) - DW'(in_a[k]);
        g1.ac[k] <= DW'(in_c[k]) - DW'(in_a[k]);
        g1.bc[k] <= DW'(in_c[k]) - DW'(in_b[k]);
        g1.a[k]  <= in_a[k];
        g1.b[k]  <= in_b[k];
        g1.c[k]  <= in_c[k];
        s1_ap[k] <= DW'(in_p[k]) - DW'(in_a[k]);
        s1_bp[k] <= DW'(in_p[k]) - DW'(in_b[k]);
        s1_cp[k] <= DW'(in_p[k]) - DW'(in_c[k]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: 18 component products for d1..d6
  //   d1 = ab.ap  d2 = ac.ap  d3 = ab.bp  d4 = ac.bp  d5 = ab.cp  d6 = ac.cp
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] eu [6][3];
  logic signed [DW-1:0] pu [6][3];
  logic signed [PW-1:0] s2_pr [6][3];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 3; k++) begin
        eu[j][k] = (j == 0 || j == 2 || j == 4) ? $signed(g1.ab[k]) : $signed(g1.ac[k]);
        pu[j][k] = (j < 2) ? s1_ap[k] : (j < 4) ? s1_bp[k] : s1_cp[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        for (int k = 0; k < 3; k++) begin
          s2_pr[j][k] <= PW'(eu[j][k]) * PW'(pu[j][k]);
        end
      end
      g2 <= g1;
    end
  end

  // Stage 3: dot products
  logic signed [DOTW-1:0] s3_d [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s3_d[j] <= DOTW'(s2_pr[j][0]) + DOTW'(s2_pr[j][1]) + DOTW'(s2_pr[j][2]);
      end
      g3 <= g2;
    end
  end

  // Stage 4: partial products of the six dot-product pairs (split in halves)
  logic signed [2*HL-1:0] s4_hh [6];
  logic signed [2*HL:0]   s4_hl [6];
  logic signed [2*HL:0]   s4_lh [6];
  logic [2*HL-1:0]        s4_ll [6];
  logic signed [DOTW-1:0] s4_d  [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s4_hh[j] <= $signed(s3_d[PA[j]][DOTW-1:HL]) * $signed(s3_d[PB[j]][DOTW-1:HL]);
        s4_hl[j] <= $signed(s3_d[PA[j]][DOTW-1:HL]) * $signed({1'b0, s3_d[PB[j]][HL-1:0]});
        s4_lh[j] <= $signed({1'b0, s3_d[PA[j]][HL-1:0]}) * $signed(s3_d[PB[j]][DOTW-1:HL]);
        s4_ll[j] <= s3_d[PA[j]][HL-1:0] * s3_d[PB[j]][HL-1:0];
        s4_d[j]  <= s3_d[j];
      end
      g4 <= g3;
    end
  end

  // Stage 5: full pair products; edge-test differences
  logic signed [VW-1:0]   s5_pr [6];
  logic signed [DOTW-1:0] s5_d  [6];
  logic signed [EW-1:0]   s5_e1, s5_e2, s5_d13, s5_d26;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s5_pr[j] <= (VW'(s4_hh[j]) <<< (2 * HL)) + (VW'(s4_hl[j]) <<< HL)
                  + (VW'(s4_lh[j]) <<< HL) + VW'(s4_ll[j]);
        s5_d[j]  <= s4_d[j];
      end
      s5_e1  <= EW'(s4_d[3]) - EW'(s4_d[2]);
      s5_e2  <= EW'(s4_d[4]) - EW'(s4_d[5]);
      s5_d13 <= EW'(s4_d[0]) - EW'(s4_d[2]);
      s5_d26 <= EW'(s4_d[1]) - EW'(s4_d[5]);
      g5     <= g4;
    end
  end

  // Stage 6: barycentric weights va, vb, vc
  logic signed [VW-1:0]   s6_va, s6_vb, s6_vc;
  logic signed [DOTW-1:0] s6_d [6];
  logic signed [EW-1:0]   s6_e1, s6_e2, s6_d13, s6_d26;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_vc  <= s5_pr[0] - s5_pr[1];
      s6_vb  <= s5_pr[2] - s5_pr[3];
      s6_va  <= s5_pr[4] - s5_pr[5];
      s6_d   <= s5_d;
      s6_e1  <= s5_e1;
      s6_e2  <= s5_e2;
      s6_d13 <= s5_d13;
      s6_d26 <= s5_d26;
      g6     <= g5;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: region classification. Tests run in the usual order: vertex A,
  // vertex B, edge AB, vertex C, edge AC, edge BC, then the face. The
  // closest point is then base + (u1*m1 + u2*m2) / den, rounded.
  // ---------------------------------------------------------------------
  logic [2:0]                c_code;
  logic signed [DENW-1:0]    c_den, c_m1, c_m2;
  logic signed [DW-1:0]      c_u1 [3];
  logic signed [DW-1:0]      c_u2 [3];
  logic [2:0][CW-1:0]        c_base;

  always_comb begin
    c_code = cpt_pkg::RG_FACE;
    c_den  = DENW'(s6_va) + DENW'(s6_vb) + DENW'(s6_vc);
    c_m1   = DENW'(s6_vb);
    c_m2   = DENW'(s6_vc);
    c_base = g6.a;
    for (int k = 0; k < 3; k++) begin
      c_u1[k] = $signed(g6.ab[k]);
      c_u2[k] = $signed(g6.ac[k]);
    end
    priority if (le0(DENW'(s6_d[0])) && le0(DENW'(s6_d[1]))) begin
      c_code = cpt_pkg::RG_A;
      c_m1   = '0;
      c_m2   = '0;
    end else if (!s6_d[2][DOTW-1] && le0(DENW'(s6_e1))) begin
      c_code = cpt_pkg::RG_B;
      c_base = g6.b;
      c_m1   = '0;
      c_m2   = '0;
    end else if (le0(DENW'(s6_vc)) && !s6_d[0][DOTW-1] && le0(DENW'(s6_d[2]))) begin
      c_code = cpt_pkg::RG_AB;
      c_den  = DENW'(s6_d13);
      c_m1   = DENW'(s6_d[0]);
      c_m2   = '0;
    end else if (!s6_d[5][DOTW-1] && le0(DENW'(s6_e2))) begin
      c_code = cpt_pkg::RG_C;
      c_base = g6.c;
      c_m1   = '0;
      c_m2   = '0;
    end else if (le0(DENW'(s6_vb)) && !s6_d[1][DOTW-1] && le0(DENW'(s6_d[5]))) begin
      c_code = cpt_pkg::RG_AC;
      c_den  = DENW'(s6_d26);
      c_m1   = DENW'(s6_d[1]);
      c_m2   = '0;
      for (int k = 0; k < 3; k++) begin
        c_u1[k] = $signed(g6.ac[k]);
      end
    end else if (le0(DENW'(s6_va)) && !s6_e1[EW-1] && !s6_e2[EW-1]) begin
      c_code = cpt_pkg::RG_BC;
      c_den  = DENW'(s6_e1) + DENW'(s6_e2);
      c_m1   = DENW'(s6_e1);
      c_m2   = '0;
      c_base = g6.b;
      for (int k = 0; k < 3; k++) begin
        c_u1[k] = $signed(g6.bc[k]);
      end
    end else begin
      c_code = cpt_pkg::RG_FACE;
    end
  end

  logic [2:0]             s7_code;
  logic signed [DENW-1:0] s7_den, s7_m1, s7_m2;
  logic signed [DW-1:0]   s7_u1 [3];
  logic signed [DW-1:0]   s7_u2 [3];
  logic [2:0][CW-1:0]     s7_base, s7_a;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_code <= c_code;
      s7_den  <= c_den;
      s7_m1   <= c_m1;
      s7_m2   <= c_m2;
      s7_u1   <= c_u1;
      s7_u2   <= c_u2;
      s7_base <= c_base;
      s7_a    <= g6.a;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: degenerate check; numerator partial products, scalar in limbs
  // ---------------------------------------------------------------------
  logic signed [MLX-1:0] ml1 [NML];
  logic signed [MLX-1:0] ml2 [NML];
  logic                  needs_div;

  always_comb begin
    for (int l = 0; l < NML; l++) begin
      ml1[l] = (l == NML - 1) ? MLX'($signed(s7_m1[ML*l +: ML]))
                              : $signed({1'b0, s7_m1[ML*l +: ML]});
      ml2[l] = (l == NML - 1) ? MLX'($signed(s7_m2[ML*l +: ML]))
                              : $signed({1'b0, s7_m2[ML*l +: ML]});
    end
    needs_div = (s7_code == cpt_pkg::RG_AB) || (s7_code == cpt_pkg::RG_AC) ||
                (s7_code == cpt_pkg::RG_BC) || (s7_code == cpt_pkg::RG_FACE);
  end

  logic signed [PPW-1:0]  s8_pp [3][2][NML];
  logic signed [DENW-1:0] s8_den, s9_den, s10_den, s11_den;
  cpt_pkg::tag_t          s8_tag, s9_tag, s10_tag, s11_tag, s12_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < NML; l++) begin
          s8_pp[k][0][l] <= PPW'(s7_u1[k]) * PPW'(ml1[l]);
          s8_pp[k][1][l] <= PPW'(s7_u2[k]) * PPW'(ml2[l]);
        end
      end
      s8_den     <= s7_den;
      s8_tag.neg <= '0;
      if (needs_div && le0(s7_den)) begin
        s8_tag.region <= cpt_pkg::RG_DEGEN;
        s8_tag.base   <= s7_a;
      end else begin
        s8_tag.region <= s7_code;
        s8_tag.base   <= s7_base;
      end
    end
  end

  // Stage 9: per-product numerator sums; stage 10: total numerator
  logic signed [NUMW-1:0] s9_nt [3][2];
  logic signed [NUMW-1:0] s10_n [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int t = 0; t < 2; t++) begin
          s9_nt[k][t] <= NUMW'(s8_pp[k][t][0]) + (NUMW'(s8_pp[k][t][1]) <<< ML)
                       + (NUMW'(s8_pp[k][t][2]) <<< (2 * ML))
                       + (NUMW'(s8_pp[k][t][3]) <<< (3 * ML));
        end
        s10_n[k] <= s9_nt[k][0] + s9_nt[k][1];
      end
      s9_den  <= s8_den;
      s9_tag  <= s8_tag;
      s10_den <= s9_den;
      s10_tag <= s9_tag;
    end
  end

  // Stage 11: magnitude and sign; stage 12: rounding numerator 2|n| + den
  logic [NUMW-1:0]         s11_abs [3];
  logic [NPW-1:0]          s12_num [3];
  logic [DENW:0]           s12_den2;

  always_ff @(posedge clk) begin
    if (en) begin
      s11_den        <= s10_den;
      s11_tag.region <= s10_tag.region;
      s11_tag.base   <= s10_tag.base;
      for (int k = 0; k < 3; k++) begin
        s11_tag.neg[k] <= s10_n[k][NUMW-1];
        s11_abs[k]     <= s10_n[k][NUMW-1] ? NUMW'(-s10_n[k]) : NUMW'(s10_n[k]);
        s12_num[k]     <= NPW'({s11_abs[k], 1'b0}) + NPW'(s11_den);
      end
      s12_den2 <= {s11_den, 1'b0};
      s12_tag  <= s11_tag;
    end
  end

  // ---------------------------------------------------------------------
  // Dividers, one per coordinate, with the tag riding alongside
  // ---------------------------------------------------------------------
  logic [QW-1:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (s12_num[k]),
      .den2 (s12_den2),
      .quo  (quo[k])
    );
  end

  cpt_pkg::tag_t tdl [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      tdl[0] <= s12_tag;
      for (int i = 1; i <= QW; i++) begin
        tdl[i] <= tdl[i-1];
      end
    end
  end

  // Final: signed quotient plus base, saturated to 32 bits; vertex and degenerate regions give the base alone
  cpt_pkg::tag_t          ft;
  logic signed [QW:0]     qx [3];
  logic signed [TW-1:0]   tot [3];
  cpt_pkg::coord_t        res [3];
  logic                   is_vert;

  always_comb begin
    ft      = tdl[QW];
    is_vert = (ft.region == cpt_pkg::RG_A) || (ft.region == cpt_pkg::RG_B) ||
              (ft.region == cpt_pkg::RG_C) || (ft.region == cpt_pkg::RG_DEGEN);
    for (int k = 0; k < 3; k++) begin
      qx[k]  = ft.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
      tot[k] = TW'($signed(ft.base[k])) + TW'(qx[k]);
      if (is_vert) begin
        res[k] = $signed(ft.base[k]);
      end else if (tot[k] > SMAX) begin
        res[k] = SMAX[CW-1:0];
      end else if (tot[k] < SMIN) begin
        res[k] = SMIN[CW-1:0];
      end else begin
        res[k] = tot[k][CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register with one-beat skid buffer
  // ---------------------------------------------------------------------
  logic            push, take;
  cpt_pkg::coord_t o_near [3];
  cpt_pkg::coord_t s_near [3];
  logic [2:0]      o_region, s_region;

  assign push = en && v[NST];
  assign take = ov && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || take) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || take) begin
      if (sv) begin
        o_near   <= s_near;
        o_region <= s_region;
      end else begin
        o_near   <= res;
        o_region <= ft.region;
      end
    end else if (push) begin
      s_near   <= res;
      s_region <= ft.region;
    end
  end

  assign rsp.valid  = ov;
  assign rsp.near_x = o_near[0];
  assign rsp.near_y = o_near[1];
  assign rsp.near_z = o_near[2];
  assign rsp.region = o_region;

`ifndef SYNTHESIS
  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid holds a beat while output register is empty");
  // a drained output with a full skid is refilled at once
  a_skid_refill: assert property (@(posedge clk) disable iff (rst)
    (sv && rsp.ready) |=> (ov && !sv))
    else $error("skid beat not moved to output register");
  // a pipeline beat into an empty output shows up next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !ov) |=> ov)
    else $error("pipeline beat lost at the output");
  // reset empties the pipe
  a_reset_clear: assert property (@(posedge clk) rst |=> (v == '0 && !ov && !sv))
    else $error("valid state survives reset");
`endif

endmodule

/* sim/closest_point_on_triangle_top_test.sv */
`timescale 1ns / 1ps

module closest_point_on_triangle_top_test;

  typedef cpt_pkg::coord_t coord_t;

  // Exact integer math; 256 bits holds every intermediate without overflow.
  typedef logic signed [255:0] wide_t;
  typedef wide_t vec_t [3];

  typedef struct {
    coord_t p [3];
    coord_t a [3];
    coord_t b [3];
    coord_t c [3];
  } query_t;

  typedef struct {
    coord_t     near [3];
    logic [2:0] region;
  } nearest_t;

  typedef struct {
    query_t   q;
    bit       typed;
    nearest_t want;
  } row_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = -32'sh7fff_ffff - 1;
  localparam int RANDOM_BEATS = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst;

  cpt_in_if  req ();
  cpt_out_if rsp ();

  closest_point_on_triangle_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Closest-point predictor
  // ---------------------------------------------------------------------

  function automatic wide_t dot3(vec_t u, vec_t v);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  // Round to nearest, ties away from zero; den > 0; magnitude caps at 2^40.
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t mag;
    wide_t quo;
    mag = (num < 0) ? -num : num;
    quo = (2 * mag + den) / (2 * den);
    if (quo > (wide_t'(1) <<< 40)) quo = wide_t'(1) <<< 40;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic nearest_t saturate(vec_t pt, logic [2:0] region);
    nearest_t r;
    for (int k = 0; k < 3; k++) begin
      if (pt[k] > wide_t'(CMAX)) r.near[k] = CMAX;
      else if (pt[k] < wide_t'(CMIN)) r.near[k] = CMIN;
      else r.near[k] = coord_t'(pt[k]);
    end
    r.region = region;
    return r;
  endfunction

  function automatic nearest_t closest_point(query_t q);
    vec_t p, a, b, c, ab, ac, bc, ap, bp, cp, pt;
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, e1, e2;
    for (int k = 0; k < 3; k++) begin
      p[k] = q.p[k];
      a[k] = q.a[k];
      b[k] = q.b[k];
      c[k] = q.c[k];
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k];
      bp[k] = p[k] - b[k];
      cp[k] = p[k] - c[k];
    end
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    if (d1 <= 0 && d2 <= 0) return saturate(a, cpt_pkg::RG_A);

    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    if (d3 >= 0 && d4 - d3 <= 0) return saturate(b, cpt_pkg::RG_B);

    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      den = d1 - d3;
      if (den <= 0) return saturate(a, cpt_pkg::RG_DEGEN);
      for (int k = 0; k < 3; k++) pt[k] = a[k] + div_round(ab[k] * d1, den);
      return saturate(pt, cpt_pkg::RG_AB);
    end

    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    if (d6 >= 0 && d5 - d6 <= 0) return saturate(c, cpt_pkg::RG_C);

    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      den = d2 - d6;
      if (den <= 0) return saturate(a, cpt_pkg::RG_DEGEN);
      for (int k = 0; k < 3; k++) pt[k] = a[k] + div_round(ac[k] * d2, den);
      return saturate(pt, cpt_pkg::RG_AC);
    end

    va = d3 * d6 - d5 * d4;
    e1 = d4 - d3;
    e2 = d5 - d6;
    if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      den = e1 + e2;
      if (den <= 0) return saturate(a, cpt_pkg::RG_DEGEN);
      for (int k = 0; k < 3; k++) pt[k] = b[k] + div_round(bc[k] * e1, den);
      return saturate(pt, cpt_pkg::RG_BC);
    end

    den = va + vb + vc;
    if (den <= 0) return saturate(a, cpt_pkg::RG_DEGEN);
    for (int k = 0; k < 3; k++) pt[k] = a[k] + div_round(ab[k] * vb + ac[k] * vc, den);
    return saturate(pt, cpt_pkg::RG_FACE);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  row_t directed [$];
  nearest_t pending [$];   // expected results, oldest first
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned errors;
  int unsigned cycles;
  int unsigned region_hits [8];
  bit stim_done;

  function automatic query_t mk(coord_t px, coord_t py, coord_t pz,
                                coord_t ax, coord_t ay, coord_t az,
                                coord_t bx, coord_t by, coord_t bz,
                                coord_t cx, coord_t cy, coord_t cz);
    query_t q;
    q.p = '{px, py, pz};
    q.a = '{ax, ay, az};
    q.b = '{bx, by, bz};
    q.c = '{cx, cy, cz};
    return q;
  endfunction

  task automatic add_row(query_t q, bit typed = 0, coord_t x = 0, coord_t y = 0,
                         coord_t z = 0, logic [2:0] region = cpt_pkg::RG_A);
    row_t r;
    r.q = q;
    r.typed = typed;
    r.want.near = '{x, y, z};
    r.want.region = region;
    directed.push_back(r);
  endtask

  function automatic coord_t rand_span(int unsigned span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic coord_t rand_corner();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return -1;
      default: return ONE;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int unsigned span;
    int unsigned kind;
    int unsigned sel;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0: span = 32'h100;
      1: span = 32'h10000;
      default: span = 32'h100_0000;
    endcase
    for (int k = 0; k < 3; k++) begin
      q.p[k] = rand_span(span);
      q.a[k] = rand_span(span);
      q.b[k] = rand_span(span);
      q.c[k] = rand_span(span);
    end
    case (kind)
      4, 5: begin
        for (int k = 0; k < 3; k++) begin
          q.p[k] = $urandom;
          q.a[k] = $urandom;
          q.b[k] = $urandom;
          q.c[k] = $urandom;
        end
      end
      6: begin
        // repeated vertices or a collinear triangle
        sel = $urandom_range(0, 3);
        for (int k = 0; k < 3; k++) begin
          case (sel)
            0: q.b[k] = q.a[k];
            1: q.c[k] = q.a[k];
            2: q.c[k] = q.b[k];
            default: q.c[k] = q.a[k] + 2 * (q.b[k] - q.a[k]);
          endcase
        end
      end
      7: begin
        for (int k = 0; k < 3; k++) begin
          q.p[k] = rand_corner();
          q.a[k] = rand_corner();
          q.b[k] = rand_corner();
          q.c[k] = rand_corner();
        end
      end
      8, 9: begin
        // point close to the triangle: a blend of the vertices plus jitter
        for (int k = 0; k < 3; k++)
          q.p[k] = (q.a[k] >>> 2) + (q.b[k] >>> 2) + (q.c[k] >>> 1) + rand_span(span >> 2);
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic drive(query_t q);
    req.valid    <= 1'b1;
    req.point_x  <= q.p[0];
    req.point_y  <= q.p[1];
    req.point_z  <= q.p[2];
    req.vert_a_x <= q.a[0];
    req.vert_a_y <= q.a[1];
    req.vert_a_z <= q.a[2];
    req.vert_b_x <= q.b[0];
    req.vert_b_y <= q.b[1];
    req.vert_b_z <= q.b[2];
    req.vert_c_x <= q.c[0];
    req.vert_c_y <= q.c[1];
    req.vert_c_z <= q.c[2];
  endtask

  // Offer one beat, wait for the handshake, then sometimes idle for a random gap.
  task automatic send(query_t q, bit typed, nearest_t want);
    int unsigned gap;
    drive(q);
    do @(posedge clk); while (!req.ready);
    if (typed) pending.push_back(want);
    else pending.push_back(closest_point(q));
    beats_in++;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    nearest_t none;
    req.valid <= 1'b0;
    {req.point_x, req.point_y, req.point_z} <= '0;
    {req.vert_a_x, req.vert_a_y, req.vert_a_z} <= '0;
    {req.vert_b_x, req.vert_b_y, req.vert_b_z} <= '0;
    {req.vert_c_x, req.vert_c_y, req.vert_c_z} <= '0;
    rst <= 1'b1;
    stim_done = 0;
    none = '{near: '{0, 0, 0}, region: cpt_pkg::RG_A};

    // Unit right triangle a=0, b=x, c=y; point on a vertex lands in its region.
    add_row(mk(0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, 0, 0, 0, cpt_pkg::RG_A);
    add_row(mk(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, ONE, 0, 0, cpt_pkg::RG_B);
    add_row(mk(0, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, 0, ONE, 0, cpt_pkg::RG_C);
    // Behind a: still vertex a.
    add_row(mk(-ONE, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, 0, 0, 0,
            cpt_pkg::RG_A);
    // Edge regions and face, including odd rounding.
    add_row(mk(ONE >>> 1, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    add_row(mk(-ONE, ONE >>> 1, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    add_row(mk(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    add_row(mk(ONE >>> 2, ONE >>> 2, 5 * ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    add_row(mk(1, 1, -7, 0, 0, 0, 3, 0, 0, 0, 3, 0));
    add_row(mk(1, 2, 1, 0, 0, 0, 3, 1, 0, 1, 3, 0));
    // All three vertices equal: nothing to project onto.
    add_row(mk(ONE, ONE, ONE, 5, 5, 5, 5, 5, 5, 5, 5, 5), 1, 5, 5, 5, cpt_pkg::RG_A);
    // Collinear and degenerate-edge triangles.
    add_row(mk(ONE, 5 * ONE, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0));
    add_row(mk(ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 2 * ONE, 0, 0));
    add_row(mk(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, 0));
    add_row(mk(-ONE, 3 * ONE, 0, 0, 0, 0, 2 * ONE, 0, 0, ONE, 0, 0));
    // Coordinate extremes; results may saturate.
    add_row(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN),
            1, CMIN, CMIN, CMIN, cpt_pkg::RG_A);
    add_row(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
            1, CMAX, CMAX, CMAX, cpt_pkg::RG_A);
    add_row(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
    add_row(mk(CMIN, CMAX, 0, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
    add_row(mk(0, 0, CMAX, CMIN, CMIN, 0, CMAX, CMIN, 0, 0, CMAX, 0));
    add_row(mk(CMAX, CMIN, -1, -1, -1, -1, CMIN, CMAX, 1, CMAX, CMAX, CMIN));
    add_row(mk(-1, -1, -1, CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send(directed[i].q, directed[i].typed, directed[i].want);
    repeat (RANDOM_BEATS) send(rand_query(), 0, none);
    req.valid <= 1'b0;
    stim_done = 1;
  end

  // ---------------------------------------------------------------------
  // Result side: random ready, plus one long hold-off while beats keep coming
  // ---------------------------------------------------------------------

  int unsigned hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= 400) begin
      // long enough to fill the pipeline and back up the input
      rsp.ready <= 1'b0;
      hold_left <= 250;
      hold_done <= 1;
    end else if (beats_in > 800 && beats_in < 900) begin
      rsp.ready <= 1'b1;     // a stretch with no stalls
    end else if ($urandom_range(0, 40) == 0) begin
      rsp.ready <= 1'b0;
      hold_left <= $urandom_range(5, 30);
    end else begin
      rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Scoreboard: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    nearest_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      beats_out++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h %h region %0d", $time,
                 rsp.near_x, rsp.near_y, rsp.near_z, rsp.region);
      end else begin
        want = pending.pop_front();
        region_hits[want.region]++;
        if (rsp.near_x !== want.near[0] || rsp.near_y !== want.near[1] ||
            rsp.near_z !== want.near[2] || rsp.region !== want.region) begin
          errors++;
          $display("%0t: result mismatch: expected %h %h %h region %0d,",
                   $time, want.near[0], want.near[1], want.near[2], want.region,
                   " got %h %h %h region %0d",
                   rsp.near_x, rsp.near_y, rsp.near_z, rsp.region);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending.size());
      $display("closest_point_on_triangle_top verification failed");
      $finish;
    end
  end

  // End of run: drain, give stray results a chance to show up, then report.
  initial begin
    wait (stim_done);
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d queries, %0d results; regions a/b/ab/c/ac/bc/face/degen:",
             beats_in, beats_out,
             " %0d %0d %0d %0d %0d %0d %0d %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3],
             region_hits[4], region_hits[5], region_hits[6], region_hits[7]);
    $display("Included a long output stall and random gaps on both sides.");
    if (errors == 0 && pending.size() == 0) begin
      $display("closest_point_on_triangle_top verification clean");
    end else begin
      $display("closest_point_on_triangle_top verification failed");
    end
    $finish;
  end

endmodule
